// ----- hdl/grouped_distinct_value_cost_assert.svh -----
// Assertion macros shared by the grouped distinct value cost RTL.
// Plain text macros; no package or module dependencies.
`ifndef GROUPED_DISTINCT_VALUE_COST_ASSERT_SVH
`define GROUPED_DISTINCT_VALUE_COST_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define GDVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define GDVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hdl/gdvc_pkg.sv -----
// Package for the grouped distinct value cost block: sizes, item types,
// and the group event passed from the tag lookup to the accumulator.
`timescale 1ns / 1ps

package gdvc_pkg;

  localparam int ID_W      = 10;   // class_id field width
  localparam int ID_BITS   = 10;   // tag store index bits, at most ID_W
  localparam int ID_DEPTH  = 2 ** ID_BITS;
  localparam int GEN_BITS  = 12;
  localparam int DIST_W    = 11;
  localparam int SUM_W     = 32;
  localparam int TALLY_W   = 16;

  localparam logic [GEN_BITS-1:0] GEN_FIRST = GEN_BITS'(1);
  localparam logic [GEN_BITS-1:0] GEN_LAST  = '1;
  localparam logic [GEN_BITS-1:0] TAG_CLEAR = '0;
  localparam logic [DIST_W-1:0]   DIST_MAX  = '1;
  localparam logic [TALLY_W-1:0]  TALLY_MAX = '1;
  localparam logic [SUM_W-1:0]    SUM_MAX   = '1;

  typedef struct packed {
    logic [ID_W-1:0] class_id;
    logic            group_end;
    logic            subpart_end;
    logic            core_end;
  } in_item_t;

  typedef struct packed {
    logic [SUM_W-1:0]   core_cost;
    logic [TALLY_W-1:0] subpart_count;
    logic [SUM_W-1:0]   worst_cost;
    logic [SUM_W-1:0]   total_cost;
  } out_item_t;

  // One processed item as seen by the accumulator.
  typedef struct packed {
    logic              fire;
    logic              grp_end;
    logic              sub_end;   // already qualified by grp_end
    logic              core_end;  // already qualified by sub_end
    logic [DIST_W-1:0] distinct;  // group count including this item
  } group_ev_t;

  function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
                                               input logic [SUM_W-1:0] b);
    logic [SUM_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[SUM_W] ? SUM_MAX : s[SUM_W-1:0];
  endfunction

endpackage

// ----- hdl/gdvc_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies; read during write to the same entry returns old data.
`timescale 1ns / 1ps

module gdvc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- hdl/gdvc_seen.sv -----
// Seen-set lookup: generation tag store, write-back forwarding, wrap sweep
// and per-group distinct counter. Uses gdvc_pkg and gdvc_ram.
`timescale 1ns / 1ps

`include "grouped_distinct_value_cost_assert.svh"

module gdvc_seen (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  gdvc_pkg::in_item_t    in_item_i,
  input  logic                  core_ready_i,
  output gdvc_pkg::group_ev_t   ev_o
);

  logic                            s1_valid_q, s1_valid_d;
  gdvc_pkg::in_item_t              s1_q, s1_d;
  logic [gdvc_pkg::GEN_BITS-1:0]   gen_q, gen_d;
  logic [gdvc_pkg::DIST_W-1:0]     dist_q, dist_d, dist_inc;
  logic                            sweep_q, sweep_d;
  logic [gdvc_pkg::ID_BITS-1:0]    sweep_cnt_q, sweep_cnt_d;
  logic                            lw_vld_q, lw_vld_d;
  logic [gdvc_pkg::ID_BITS-1:0]    lw_addr_q, lw_addr_d;
  logic [gdvc_pkg::GEN_BITS-1:0]   lw_data_q, lw_data_d;

  logic                            accept, fire, wraps, is_new, tag_we;
  logic [gdvc_pkg::ID_BITS-1:0]    s1_idx, ram_waddr;
  logic [gdvc_pkg::GEN_BITS-1:0]   ram_rdata, ram_wdata, tag_eff;

  assign s1_idx = s1_q.class_id[gdvc_pkg::ID_BITS-1:0];

  // Hold s1 only for a core end the output register cannot take.
  assign fire   = s1_valid_q && (!s1_q.core_end || core_ready_i);
  assign wraps  = s1_q.group_end && (gen_q == gdvc_pkg::GEN_LAST);

  // No new item while sweeping, while s1 is held, or in the cycle a wrap starts a sweep.
  assign in_stall_o = sweep_q || (s1_valid_q && (!fire || wraps));
  assign accept     = in_valid_i && !in_stall_o;

  // Read issued at accept saw memory before the s1 write of that same edge.
  assign tag_eff = (lw_vld_q && (lw_addr_q == s1_idx)) ? lw_data_q : ram_rdata;
  assign is_new  = (tag_eff != gen_q);
  assign tag_we  = fire && is_new;

  assign ram_waddr = sweep_q ? sweep_cnt_q : s1_idx;
  assign ram_wdata = sweep_q ? gdvc_pkg::TAG_CLEAR : gen_q;

  gdvc_ram #(
    .WIDTH (gdvc_pkg::GEN_BITS),
    .DEPTH (gdvc_pkg::ID_DEPTH)
  ) u_tag_ram (
    .clk_i   (clk_i),
    .we_i    (sweep_q || tag_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (accept),
    .raddr_i (in_item_i.class_id[gdvc_pkg::ID_BITS-1:0]),
    .rdata_o (ram_rdata)
  );

  assign dist_inc = (is_new && (dist_q != gdvc_pkg::DIST_MAX)) ?
                    dist_q + gdvc_pkg::DIST_W'(1) : dist_q;

  always_comb begin
    s1_valid_d  = accept || (s1_valid_q && !fire);
    s1_d        = s1_q;
    gen_d       = gen_q;
    dist_d      = dist_q;
    sweep_d     = sweep_q;
    sweep_cnt_d = sweep_cnt_q;
    lw_vld_d    = lw_vld_q;
    lw_addr_d   = lw_addr_q;
    lw_data_d   = lw_data_q;

    if (accept) begin
      s1_d.class_id    = in_item_i.class_id;
      s1_d.group_end   = in_item_i.group_end;
      s1_d.subpart_end = in_item_i.group_end && in_item_i.subpart_end;
      s1_d.core_end    = in_item_i.group_end && in_item_i.subpart_end &&
                         in_item_i.core_end;
      lw_vld_d  = tag_we;
      lw_addr_d = s1_idx;
      lw_data_d = gen_q;
    end

    if (sweep_q) begin
      sweep_cnt_d = sweep_cnt_q + gdvc_pkg::ID_BITS'(1);
      if (sweep_cnt_q == '1) begin
        sweep_d = 1'b0;
      end
    end

    if (fire) begin
      dist_d = s1_q.group_end ? '0 : dist_inc;
      if (s1_q.group_end) begin
        if (wraps) begin
          gen_d       = gdvc_pkg::GEN_FIRST;
          sweep_d     = 1'b1;
          sweep_cnt_d = '0;
        end else begin
          gen_d = gen_q + gdvc_pkg::GEN_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      gen_q       <= gdvc_pkg::GEN_FIRST;
      dist_q      <= '0;
      sweep_q     <= 1'b1;
      sweep_cnt_q <= '0;
      lw_vld_q    <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      gen_q       <= gen_d;
      dist_q      <= dist_d;
      sweep_q     <= sweep_d;
      sweep_cnt_q <= sweep_cnt_d;
      lw_vld_q    <= lw_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_q      <= s1_d;
    lw_addr_q <= lw_addr_d;
    lw_data_q <= lw_data_d;
  end

  always_comb begin
    ev_o.fire     = fire;
    ev_o.grp_end  = s1_q.group_end;
    ev_o.sub_end  = s1_q.subpart_end;
    ev_o.core_end = s1_q.core_end;
    ev_o.distinct = dist_inc;
  end

  `GDVC_ASSERT_NOW(a_no_accept_in_sweep, sweep_q, !accept, "item accepted during sweep")
  `GDVC_ASSERT_NEXT(a_wrap_starts_sweep, fire && wraps,
                    sweep_q && (gen_q == gdvc_pkg::GEN_FIRST) && !s1_valid_q,
                    "wrap did not start a clean sweep")
  `GDVC_ASSERT_NEXT(a_s1_holds, s1_valid_q && !fire, s1_valid_q && $stable(s1_q),
                    "held item lost or changed")
  `GDVC_ASSERT_NOW(a_sweep_s1_empty, sweep_q, !s1_valid_q, "item in flight during sweep")

endmodule

// ----- hdl/gdvc_accum.sv -----
// Core accumulator: saturating core cost, subpartition tally, running worst
// and total, and the output item register. Uses gdvc_pkg.
`timescale 1ns / 1ps

`include "grouped_distinct_value_cost_assert.svh"

module gdvc_accum (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  gdvc_pkg::group_ev_t  ev_i,
  output logic                 core_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output gdvc_pkg::out_item_t  out_item_o
);

  logic [gdvc_pkg::SUM_W-1:0]   sum_q, sum_d, worst_q, worst_d, total_q, total_d;
  logic [gdvc_pkg::TALLY_W-1:0] tally_q, tally_d;
  logic                         out_valid_q, out_valid_d;
  gdvc_pkg::out_item_t          out_q, out_d;

  logic [gdvc_pkg::SUM_W-1:0]   sum_new, worst_new, total_new;
  logic [gdvc_pkg::TALLY_W-1:0] tally_new;
  logic                         load;

  assign core_ready_o = !(out_valid_q && out_stall_i);

  assign sum_new   = gdvc_pkg::sat_add(sum_q,
                       {{(gdvc_pkg::SUM_W - gdvc_pkg::DIST_W){1'b0}}, ev_i.distinct});
  assign tally_new = (ev_i.sub_end && (tally_q != gdvc_pkg::TALLY_MAX)) ?
                     tally_q + gdvc_pkg::TALLY_W'(1) : tally_q;
  assign worst_new = (sum_new > worst_q) ? sum_new : worst_q;
  assign total_new = gdvc_pkg::sat_add(total_q, sum_new);

  assign load = ev_i.fire && ev_i.core_end;

  always_comb begin
    sum_d       = sum_q;
    tally_d     = tally_q;
    worst_d     = worst_q;
    total_d     = total_q;
    out_d       = out_q;
    out_valid_d = load || (out_valid_q && out_stall_i);

    if (ev_i.fire && ev_i.grp_end) begin
      sum_d   = sum_new;
      tally_d = tally_new;
    end
    if (load) begin
      sum_d               = '0;
      tally_d             = '0;
      worst_d             = worst_new;
      total_d             = total_new;
      out_d.core_cost     = sum_new;
      out_d.subpart_count = tally_new;
      out_d.worst_cost    = worst_new;
      out_d.total_cost    = total_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q       <= '0;
      tally_q     <= '0;
      worst_q     <= '0;
      total_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      sum_q       <= sum_d;
      tally_q     <= tally_d;
      worst_q     <= worst_d;
      total_q     <= total_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `GDVC_ASSERT_NOW(a_no_overwrite, load, core_ready_o, "unread result overwritten")
  `GDVC_ASSERT_NOW(a_worst_bound, out_valid_q,
                   (out_q.worst_cost >= out_q.core_cost) &&
                   (out_q.total_cost >= out_q.core_cost),
                   "worst or total below core cost")
  `GDVC_ASSERT_NEXT(a_core_restart, load, (sum_q == '0) && (tally_q == '0),
                    "core sums not cleared after core end")

endmodule

// ----- hdl/grouped_distinct_value_cost.sv -----
// A core-end item accepted into s1 loads the output register when it fires and is then presented.
// Throughput: one item per cycle outside sweeps; a result waiting at the output holds only a core
// end in s1, which then stalls the input. Each generation wrap (every 4095 groups) runs a sweep
// over all 1024 tag entries; the input stalls through it and while the wrapping group end is in s1.
// Reset: asynchronous, active low; afterwards a clearing pass over every tag RAM entry runs
// before the first item is taken. The tag RAM port count sets the rate.
`timescale 1ns / 1ps

// Top level: gdvc_seen (tag RAM lookup) feeding gdvc_accum (sums and output).
// Uses gdvc_pkg.

module grouped_distinct_value_cost (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gdvc_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gdvc_pkg::out_item_t out_item_o
);

  // Stage 0: accept item, issue tag read.
  // Stage 1: compare tag with generation (forwarded from same-edge write),
  //          write back, update group count; emit group event.
  // Output register: core end results wait here while the sink stalls.
  gdvc_pkg::group_ev_t ev;
  logic                core_ready;

  gdvc_seen u_seen (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .in_item_i    (in_item_i),
    .core_ready_i (core_ready),
    .ev_o         (ev)
  );

  // Group end events add into core cost; core ends load the output register.
  gdvc_accum u_accum (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ev_i         (ev),
    .core_ready_o (core_ready),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_o   (out_item_o)
  );

endmodule
